FILE: src/mersenne_twister_prng_defines.svh
// Assertion macros shared by the checker of the MT19937 generator.
// No dependencies; included by the checker file.
`ifndef MERSENNE_TWISTER_PRNG_DEFINES_SVH
`define MERSENNE_TWISTER_PRNG_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MTP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mtp check failed");

// Next-cycle implication, disabled while reset is high.
`define MTP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mtp check failed");

`endif

FILE: src/mtp_pkg.sv
// Package of the MT19937 generator: sizes, constants, RAM request struct,
// twist and temper functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mtp_pkg;

   localparam int unsigned STATE_WORDS  = 624;
   localparam int unsigned ADDR_W       = $clog2(STATE_WORDS);
   localparam int unsigned TWIST_OFFSET = 397;
   localparam int unsigned WRAP_BACK    = STATE_WORDS - TWIST_OFFSET;

   localparam logic [ADDR_W-1:0] LAST_POS   = ADDR_W'(STATE_WORDS - 1);
   localparam logic [ADDR_W-1:0] OFFSET_POS = ADDR_W'(TWIST_OFFSET);
   localparam logic [ADDR_W-1:0] WRAP_POS   = ADDR_W'(WRAP_BACK);

   localparam logic [31:0] INIT_MULT    = 32'd1812433253;
   localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
   localparam logic [31:0] LOW_BITS     = 32'h7fff_ffff;
   localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
   localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
   localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [31:0]       wr_data;
      logic [ADDR_W-1:0] rd_addr_a;
      logic [ADDR_W-1:0] rd_addr_b;
   } ram_req_type;

   function automatic logic [31:0] twist(input logic [31:0] cur, input logic [31:0] nxt,
                                         input logic [31:0] far);
      logic [31:0] y;
      logic [31:0] v;
      y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
      v = far ^ (y >> 1);
      if (y[0]) begin
         v = v ^ TWIST_MATRIX;
      end
      return v;
   endfunction

   function automatic logic [31:0] temper(input logic [31:0] w);
      logic [31:0] y;
      y = w;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

`default_nettype wire

FILE: src/mtp_state_ram.sv
// State word memory of the MT19937 generator: 624 x 32, one write port,
// two registered read ports. Depends on mtp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtp_state_ram (
   input  wire logic                 clock,
   input  wire mtp_pkg::ram_req_type req,
   output logic [31:0]               rd_a,
   output logic [31:0]               rd_b
);

   logic [31:0] mem_ff [mtp_pkg::STATE_WORDS];
   logic [31:0] rd_a_ff;
   logic [31:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem_ff[req.wr_addr] <= req.wr_data;
      end
      rd_a_ff <= mem_ff[req.rd_addr_a];
      rd_b_ff <= mem_ff[req.rd_addr_b];
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

`default_nettype wire

FILE: src/mtp_seed_unit.sv
// Seeding recurrence of the MT19937 generator: registered 32x32 multiply,
// then add of the word index. Depends on mtp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtp_seed_unit (
   input  wire logic                       clock,
   input  wire logic                       load,
   input  wire logic [31:0]                seed,
   input  wire logic                       mul_en,
   input  wire logic                       add_en,
   input  wire logic [mtp_pkg::ADDR_W-1:0] index,
   output logic [31:0]                     word
);

   logic [31:0] prev_ff;
   logic [31:0] prev_in;
   logic [31:0] prod_ff;
   logic [31:0] prod_in;
   logic [31:0] mix;

   assign mix     = prev_ff ^ (prev_ff >> 30);
   assign prod_in = 32'(mtp_pkg::INIT_MULT * mix);
   assign word    = prod_ff + 32'(index);

   always_comb begin
      prev_in = prev_ff;
      if (load) begin
         prev_in = seed;
      end else if (add_en) begin
         prev_in = word;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/mersenne_twister_prng.sv
// Draw: the accepting edge enters TWIST, whose output is the registered result
// strobe (the first draw after a reseed passes MISS first to fetch the current word);
// a new draw is accepted once idle again, in the cycle its predecessor is shown.
// Reseed: busy after acceptance for 623 words (multiply then add for each),
// no result. Reset: idle, read position 0; state words undefined until seeded.
// The receiver cannot stall: each result is shown for one cycle only.
`timescale 1ns / 1ps
`default_nettype none

module mersenne_twister_prng (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_action,
   input  wire logic [31:0] req_seed,
   output logic             rsp_strobe,
   output logic [31:0]      rsp_random_word
);

   // One-hot control sequencer
   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_MISS     = 5'b00010,
      ST_TWIST    = 5'b00100,
      ST_SEED_MUL = 5'b01000,
      ST_SEED_ADD = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Twist is done on the fly: drawing word p replaces it with its new
   // value, from old p, old p+1 and word p+397 (already new once it wraps).
   // This matches the bulk regeneration word for word.
   logic [mtp_pkg::ADDR_W-1:0] pos_ff;
   logic [mtp_pkg::ADDR_W-1:0] pos_in;
   logic [mtp_pkg::ADDR_W-1:0] next_pos;
   logic [mtp_pkg::ADDR_W-1:0] far_pos;

   // Cached old value of word p, taken from port b during the previous draw (port a on a miss)
   logic [31:0] cur_ff;
   logic [31:0] cur_in;
   logic        cur_valid_ff;
   logic        cur_valid_in;

   logic [mtp_pkg::ADDR_W-1:0] seed_idx_ff;
   logic [mtp_pkg::ADDR_W-1:0] seed_idx_in;

   logic        rsp_strobe_ff;
   logic        rsp_strobe_in;
   logic [31:0] rsp_word_ff;
   logic [31:0] rsp_word_in;

   logic        accept;
   logic [31:0] twisted;
   logic [31:0] seed_word;

   mtp_pkg::ram_req_type ram_req;
   logic [31:0]          rd_a;
   logic [31:0]          rd_b;

   assign accept   = start && (state_ff == ST_IDLE);
   assign next_pos = (pos_ff == mtp_pkg::LAST_POS) ? '0 : pos_ff + 1'b1;
   assign far_pos  = (pos_ff < mtp_pkg::WRAP_POS) ? pos_ff + mtp_pkg::OFFSET_POS
                                                  : pos_ff - mtp_pkg::WRAP_POS;
   assign twisted  = mtp_pkg::twist(cur_ff, rd_b, rd_a);

   mtp_state_ram u_ram (
      .clock (clock),
      .req   (ram_req),
      .rd_a  (rd_a),
      .rd_b  (rd_b)
   );

   mtp_seed_unit u_seed (
      .clock  (clock),
      .load   (accept && !req_action),
      .seed   (req_seed),
      .mul_en (state_ff == ST_SEED_MUL),
      .add_en (state_ff == ST_SEED_ADD),
      .index  (seed_idx_ff),
      .word   (seed_word)
   );

   // Memory port steering. Port b always fetches p+1; port a fetches p on a
   // cache miss at acceptance and the far word otherwise.
   always_comb begin
      ram_req.rd_addr_a = far_pos;
      ram_req.rd_addr_b = next_pos;
      if ((state_ff == ST_IDLE) && !cur_valid_ff) begin
         ram_req.rd_addr_a = pos_ff;
      end
      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = pos_ff;
      ram_req.wr_data = twisted;
      unique case (state_ff)
         ST_IDLE: begin
            // word 0 of a reseed is the seed itself
            ram_req.wr_en   = accept && !req_action;
            ram_req.wr_addr = '0;
            ram_req.wr_data = req_seed;
         end
         ST_TWIST: begin
            ram_req.wr_en = 1'b1;
         end
         ST_SEED_ADD: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = seed_idx_ff;
            ram_req.wr_data = seed_word;
         end
         default: begin
            ram_req.wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      cur_in        = cur_ff;
      cur_valid_in  = cur_valid_ff;
      seed_idx_in   = seed_idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action) begin
                  state_in = cur_valid_ff ? ST_TWIST : ST_MISS;
               end else begin
                  state_in     = ST_SEED_MUL;
                  pos_in       = '0;
                  cur_valid_in = 1'b0;
                  seed_idx_in  = mtp_pkg::ADDR_W'(1);
               end
            end
         end
         ST_MISS: begin
            cur_in   = rd_a;
            state_in = ST_TWIST;
         end
         ST_TWIST: begin
            rsp_strobe_in = 1'b1;
            rsp_word_in   = mtp_pkg::temper(twisted);
            cur_in        = rd_b;
            cur_valid_in  = 1'b1;
            pos_in        = next_pos;
            state_in      = ST_IDLE;
         end
         ST_SEED_MUL: begin
            state_in = ST_SEED_ADD;
         end
         ST_SEED_ADD: begin
            if (seed_idx_ff == mtp_pkg::LAST_POS) begin
               state_in = ST_IDLE;
            end else begin
               seed_idx_in = seed_idx_ff + 1'b1;
               state_in    = ST_SEED_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pos_ff        <= '0;
         cur_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         cur_valid_ff  <= cur_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      cur_ff      <= cur_in;
      seed_idx_ff <= seed_idx_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_random_word = rsp_word_ff;

endmodule

`default_nettype wire

FILE: src/mersenne_twister_prng_checker.sv
// Port-level checker of the MT19937 generator and its bind to the top level.
// Depends on mersenne_twister_prng_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "mersenne_twister_prng_defines.svh"

module mersenne_twister_prng_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        req_action,
   input wire logic [31:0] req_seed,
   input wire logic        rsp_strobe,
   input wire logic [31:0] rsp_random_word
);

   logic unused_ok;
   assign unused_ok = ^{req_seed, rsp_random_word};

   // a transfer in always takes the block busy
   `MTP_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // a reseed takes it busy and gives no result
   `MTP_ASSERT_NEXT(a_reseed_quiet, clock, reset, start && !busy && !req_action, busy && !rsp_strobe)
   // a result shows up as the block goes idle after working
   `MTP_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_strobe, !busy && $past(busy))
   // each result is a single-cycle transfer
   `MTP_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_strobe, !rsp_strobe)

endmodule

bind mersenne_twister_prng mersenne_twister_prng_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_action      (req_action),
   .req_seed        (req_seed),
   .rsp_strobe      (rsp_strobe),
   .rsp_random_word (rsp_random_word)
);

`default_nettype wire

FILE: tb/mersenne_twister_prng_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of mersenne_twister_prng: reseeds and draws checked
// against a behavioural MT19937 generator held in the bench. Needs mtp_pkg and the RTL.
module mersenne_twister_prng_test;

   localparam int unsigned STATE_WORDS = mtp_pkg::STATE_WORDS;

   // Item codes on req_action
   localparam logic ACT_RESEED = 1'b0;
   localparam logic ACT_DRAW   = 1'b1;

   // Generator constants of the bench model
   localparam logic [31:0] SEED_MULT     = 32'd1812433253;
   localparam int unsigned FAR_OFFSET    = 397;
   localparam logic [31:0] HIGH_BIT_SEL  = 32'h8000_0000;
   localparam logic [31:0] LOW_BITS_SEL  = 32'h7fff_ffff;
   localparam logic [31:0] TWIST_XOR     = 32'h9908_b0df;
   localparam logic [31:0] TEMPER_MASK_B = 32'h9d2c_5680;
   localparam logic [31:0] TEMPER_MASK_C = 32'hefc6_0000;

   // A reseed keeps the block busy with no transfer at all while it seeds the state,
   // so the watchdog limit sits well above the length of a reseed.
   localparam int unsigned STALL_LIMIT = 8000;
   localparam int unsigned TAIL_CYCLES = 8;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        start           = 1'b0;
   logic        req_action      = ACT_DRAW;
   logic [31:0] req_seed        = '0;
   logic        busy;
   logic        rsp_strobe;
   logic [31:0] rsp_random_word;

   // Bench copy of the generator: state words and read position
   logic [31:0] gen_words [STATE_WORDS];
   int unsigned gen_pos = STATE_WORDS;

   // Tempered words still owed by the block, oldest first
   logic [31:0] word_queue [$];

   int unsigned items_sent    = 0;
   int unsigned draws_sent    = 0;
   int unsigned reseeds_sent  = 0;
   int unsigned regen_count   = 0;
   int unsigned words_checked = 0;
   int unsigned error_count   = 0;
   int unsigned stall_cycles  = 0;
   bit          gaps_on       = 1'b1;

   mersenne_twister_prng DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_seed        (req_seed),
      .rsp_strobe      (rsp_strobe),
      .rsp_random_word (rsp_random_word)
   );

   always #6 clock = ~clock;

   // Advance the bench generator by one accepted item. A reseed refills every word
   // and marks the state used up; a draw twists the whole state first when used up,
   // then tempers the word at the read position and queues it.
   function automatic void step_generator(input logic action, input logic [31:0] seed);
      logic [31:0] y;
      logic [31:0] v;
      int unsigned nxt;
      int unsigned far;
      if (action == ACT_RESEED) begin
         gen_words[0] = seed;
         for (int unsigned j = 1; j < STATE_WORDS; j++) begin
            y = gen_words[j - 1];
            gen_words[j] = SEED_MULT * (y ^ (y >> 30)) + j;
         end
         gen_pos = STATE_WORDS;
         reseeds_sent++;
      end else begin
         if (gen_pos >= STATE_WORDS) begin
            // In-place twist: later words see the already updated early ones
            for (int unsigned i = 0; i < STATE_WORDS; i++) begin
               nxt = (i + 1) % STATE_WORDS;
               far = (i + FAR_OFFSET) % STATE_WORDS;
               y = (gen_words[i] & HIGH_BIT_SEL) | (gen_words[nxt] & LOW_BITS_SEL);
               v = gen_words[far] ^ (y >> 1);
               if (y[0]) begin
                  v = v ^ TWIST_XOR;
               end
               gen_words[i] = v;
            end
            gen_pos = 0;
            regen_count++;
         end
         y = gen_words[gen_pos];
         gen_pos++;
         // 32-bit shifts drop the same bits that the masks would clear
         y = y ^ (y >> 11);
         y = y ^ ((y << 7) & TEMPER_MASK_B);
         y = y ^ ((y << 15) & TEMPER_MASK_C);
         y = y ^ (y >> 18);
         word_queue.push_back(y);
         draws_sent++;
      end
   endfunction

   // Lower start and hold off (n >= 1, so start never toggles in one step)
   task automatic pause_sender(input int unsigned n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Random burst of idle cycles after a transfer, when gaps are enabled
   task automatic maybe_pause();
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         pause_sender($urandom_range(1, 6));
      end
   endtask

   // One input transfer: present the item, hold it until an edge sees busy low.
   // start is left high, so back-to-back items see no gap in it.
   task automatic send_item(input logic action, input logic [31:0] seed);
      start      <= 1'b1;
      req_action <= action;
      req_seed   <= seed;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      step_generator(action, seed);
      items_sent++;
      maybe_pause();
   endtask

   // Directed: the classic default seed, extreme and patterned seeds, extreme
   // values in the ignored seed field of draws, and two reseeds in a row.
   task automatic test_known_seeds();
      gaps_on = 1'b1;
      send_item(ACT_RESEED, 32'd5489);
      send_item(ACT_DRAW, 32'h0000_0000);
      send_item(ACT_DRAW, 32'hffff_ffff);
      send_item(ACT_DRAW, $urandom);
      send_item(ACT_RESEED, 32'h0000_0000);
      send_item(ACT_DRAW, $urandom);
      send_item(ACT_DRAW, $urandom);
      send_item(ACT_RESEED, 32'hffff_ffff);
      send_item(ACT_DRAW, $urandom);
      send_item(ACT_RESEED, 32'h8000_0000);
      send_item(ACT_RESEED, 32'h7fff_ffff);
      send_item(ACT_DRAW, $urandom);
      send_item(ACT_DRAW, $urandom);
      send_item(ACT_RESEED, 32'haaaa_aaaa);
      send_item(ACT_DRAW, $urandom);
      send_item(ACT_RESEED, 32'h5555_5555);
      send_item(ACT_DRAW, $urandom);
   endtask

   // One seed drawn right through the end of the state, so the read position
   // runs out and the next draw has to twist all words again.
   task automatic test_state_regeneration();
      gaps_on = 1'b1;
      send_item(ACT_RESEED, $urandom);
      repeat (STATE_WORDS + 76) send_item(ACT_DRAW, $urandom);
   endtask

   // Reseed followed by a short run of draws, with random seeds and now and then
   // an extreme one. Some runs are empty (reseed straight after reseed), and most
   // reseeds land with the state part-way through.
   task automatic test_random_sequences(input int unsigned item_target);
      logic [31:0] seed;
      int unsigned run_len;
      while (items_sent < item_target) begin
         gaps_on = ($urandom_range(0, 9) < 7);
         case ($urandom_range(0, 9))
            0: begin
               seed = 32'h0000_0000;
            end
            1: begin
               seed = 32'hffff_ffff;
            end
            default: begin
               seed = $urandom;
            end
         endcase
         send_item(ACT_RESEED, seed);
         run_len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 40);
         repeat (run_len) send_item(ACT_DRAW, $urandom);
      end
   endtask

   // Sender holds off until every owed word has come back, then resumes
   task automatic test_drain_pause();
      gaps_on = 1'b1;
      repeat (12) send_item(ACT_DRAW, $urandom);
      pause_sender(1);
      while (word_queue.size() != 0) @(posedge clock);
      repeat (12) send_item(ACT_DRAW, $urandom);
   endtask

   // Closing stretch at full rate: no sender gaps at all
   task automatic test_without_gaps();
      gaps_on = 1'b0;
      send_item(ACT_RESEED, $urandom);
      repeat (150) send_item(ACT_DRAW, $urandom);
   endtask

   // Result checker: the block cannot be stalled, so every strobe is a transfer
   // and is matched against the oldest owed word.
   always @(posedge clock) begin : check_words
      logic [31:0] want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (word_queue.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual random_word %08h",
                     $time, rsp_random_word);
            error_count++;
         end else begin
            want = word_queue.pop_front();
            words_checked++;
            if (rsp_random_word !== want) begin
               $display("%0t: random_word mismatch, expected %08h, actual %08h",
                        $time, want, rsp_random_word);
               error_count++;
            end
         end
      end
   end

   // Watchdog: cycles since the last transfer on either side
   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_strobe === 1'b1) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("%0t: timeout, no transfer for %0d cycles, %0d words still owed",
               $time, STALL_LIMIT, word_queue.size());
      $display("FAIL mersenne_twister_prng");
      $finish;
   end

   initial begin
      // Synchronous reset, held from time zero and released once
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The first item is always a reseed: the state is undefined before it
      test_known_seeds();
      test_state_regeneration();
      test_random_sequences(1620);
      test_drain_pause();
      test_without_gaps();

      // Drain: every owed word back and any reseed finished, then a short tail
      // to catch stray strobes
      pause_sender(1);
      while (word_queue.size() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d transfers in: %0d reseeds, %0d draws, %0d state twists.",
               items_sent, reseeds_sent, draws_sent, regen_count);
      $display("%0d words compared, with and without sender gaps and one full drain.",
               words_checked);
      if (error_count == 0) begin
         $display("PASS mersenne_twister_prng");
      end else begin
         $display("FAIL mersenne_twister_prng");
      end
      $finish;
   end

endmodule
